FILE: rtl/pslc_pkg.sv
// Package with the event codes, status codes and record types of the stop interlock.
package pslc_pkg;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_REQ_OPER  = 3'd1,
      OP_REQ_LATCH = 3'd2,
      OP_REQ_EMERG = 3'd3,
      OP_CLR_OPER  = 3'd4,
      OP_CLR_STALL = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      CS_NONE      = 3'd0,
      CS_OK        = 3'd1,
      CS_EMERGENCY = 3'd2,
      CS_LATCHED   = 3'd3,
      CS_NO_STALL  = 3'd4
   } clear_status_type;

   typedef struct packed {
      logic pending_operational;
      logic pending_latched;
      logic pending_emergency;
      logic operational_stop;
      logic latched_stop;
      logic emergency_stop;
      logic stall_stop;
   } state_type;

   // Packed so that the last member lands in bit 0 of the response data.
   typedef struct packed {
      logic             emergency_active;
      logic             latched_or_worse;
      logic             any_stopped;
      clear_status_type clear_status;
      logic             clear_motor_stall;
      logic [7:0]       fault_cause;
      logic             stall_fault_report;
      logic             emergency_stop_cmd;
      logic             normal_stop_cmd;
   } result_type;

   localparam int unsigned RESULT_BITS = $bits(result_type);
   localparam int unsigned RSP_BITS    = 24;

endpackage

FILE: rtl/pslc_step.sv
// Next-state and result logic for one interlock event.
module pslc_step (
   input  pslc_pkg::op_type     op,
   input  logic                 motor_stalled,
   input  logic [7:0]           stall_cause,
   input  pslc_pkg::state_type  state,
   output pslc_pkg::state_type  state_next,
   output pslc_pkg::result_type result
);

   always_comb begin
      state_next = state;
      result     = '0;
      result.clear_status = pslc_pkg::CS_NONE;
      unique case (op)
         pslc_pkg::OP_TICK: begin
            // latch the stall stop when the motor is stalled and the stop is not yet latched
            if (motor_stalled && !state.stall_stop) begin
               state_next.stall_stop     = 1'b1;
               result.normal_stop_cmd    = 1'b1;
               result.stall_fault_report = 1'b1;
               result.fault_cause        = stall_cause;
            end
            // serve the highest pending request, drop the lower ones
            priority if (state.pending_emergency) begin
               state_next.pending_emergency   = 1'b0;
               state_next.pending_latched     = 1'b0;
               state_next.pending_operational = 1'b0;
               state_next.emergency_stop      = 1'b1;
               result.emergency_stop_cmd      = 1'b1;
            end else if (state.pending_latched) begin
               state_next.pending_latched     = 1'b0;
               state_next.pending_operational = 1'b0;
               state_next.latched_stop        = 1'b1;
               result.normal_stop_cmd         = 1'b1;
            end else if (state.pending_operational) begin
               state_next.pending_operational = 1'b0;
               state_next.operational_stop    = 1'b1;
               result.normal_stop_cmd         = 1'b1;
            end else begin
               // nothing pending: hold the stop levels
               state_next.operational_stop    = state.operational_stop;
            end
         end
         pslc_pkg::OP_REQ_OPER:  state_next.pending_operational = 1'b1;
         pslc_pkg::OP_REQ_LATCH: state_next.pending_latched     = 1'b1;
         pslc_pkg::OP_REQ_EMERG: state_next.pending_emergency   = 1'b1;
         pslc_pkg::OP_CLR_OPER: begin
            if (!state.latched_stop && !state.emergency_stop) begin
               state_next.pending_operational = 1'b0;
               state_next.operational_stop    = 1'b0;
            end
         end
         pslc_pkg::OP_CLR_STALL: begin
            priority if (state.emergency_stop) begin
               result.clear_status = pslc_pkg::CS_EMERGENCY;
            end else if (state.latched_stop) begin
               result.clear_status = pslc_pkg::CS_LATCHED;
            end else if (!state.stall_stop) begin
               result.clear_status = pslc_pkg::CS_NO_STALL;
            end else begin
               state_next.stall_stop    = 1'b0;
               result.clear_motor_stall = 1'b1;
               result.clear_status      = pslc_pkg::CS_OK;
            end
         end
         default: ;
      endcase
      result.any_stopped      = state_next.operational_stop | state_next.latched_stop |
                                state_next.emergency_stop | state_next.stall_stop;
      result.latched_or_worse = state_next.latched_stop | state_next.emergency_stop |
                                state_next.stall_stop;
      result.emergency_active = state_next.emergency_stop;
   end

endmodule

FILE: rtl/prioritized_stop_latch_controller.sv
// Motor stop interlock: pending stop requests, stall latch and status reporting.
//
// Each request on the req_ channel is one event: a tick carrying the sampled
// stall status and cause, a stop request of one of three levels, a clear of
// the operational stop, or a stall clear. Every request yields exactly one
// response on the rsp_ channel with the motor commands, fault and clear
// reports, and the stop status after the event.
//
// A request is captured in an input register; the step logic runs between
// that register and the response register and updates the interlock state
// in the same cycle; rsp_tvalid rises as the result enters the response register.
// One request is accepted every cycle while responses are taken.
//
// When the receiver stalls, the response holds and the input register keeps
// one more request; req_tready then drops until the response is taken.
// Reset clears all pending requests and stop levels and empties both
// registers. Emergency and latched stops are released only by reset.
module prioritized_stop_latch_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // motor_stalled[0], stall_cause[8:1], zero[15:9]
   input  logic [2:0]  req_tuser,  // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // normal_stop_cmd[0], emergency_stop_cmd[1], stall_fault_report[2],
   // fault_cause[10:3], clear_motor_stall[11], clear_status[14:12],
   // any_stopped[15], latched_or_worse[16], emergency_active[17], zero[23:18]
   output logic [23:0] rsp_tdata
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   pslc_pkg::op_type     in_op_ff;
   logic                 in_stalled_ff;
   logic [7:0]           in_cause_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   pslc_pkg::result_type out_ff;
   pslc_pkg::state_type  state_ff;
   pslc_pkg::state_type  state_in;
   pslc_pkg::state_type  state_next;
   pslc_pkg::result_type result;
   logic                 advance;
   logic                 req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   pslc_step u_step (
      .op            (in_op_ff),
      .motor_stalled (in_stalled_ff),
      .stall_cause   (in_cause_ff),
      .state         (state_ff),
      .state_next    (state_next),
      .result        (result)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      state_in     = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff      <= pslc_pkg::op_type'(req_tuser);
         in_stalled_ff <= req_tdata[0];
         in_cause_ff   <= req_tdata[8:1];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(pslc_pkg::RSP_BITS - pslc_pkg::RESULT_BITS)'(0), out_ff};

`ifndef SYNTH
   a_emergency_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.emergency_stop |=> state_ff.emergency_stop)
      else $error("emergency stop released without reset");

   a_latched_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.latched_stop |=> state_ff.latched_stop)
      else $error("latched stop released without reset");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("interlock state changed without a request moving on");

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed request produced no response");
`endif

endmodule
